// File: rtl/core/lcag_pkg.sv
// ----------------------------------------------------------------------------
// Life grid package
// Transaction types, operation codes and rule constants for the toroidal
// life grid.
// ----------------------------------------------------------------------------
`default_nettype none

package lcag_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_ADV   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [3:0] SURVIVE_MIN = 4'd2;
  localparam logic [3:0] BIRTH_COUNT = 4'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] col;
    logic [5:0] row;
    logic       cell_in;
  } in_t;

  typedef struct packed {
    logic       cell_out;
    logic [1:0] done_opcode;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/core/lcag_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lcag_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/life_cellular_automaton_grid.sv
// An accepted write or read passes through the S_CELL state; the result strobe is registered from there.
// An unused opcode or a position outside the grid answers in the cycle after acceptance.
// An advance keeps busy high while it computes one cell per cycle through a rotating
// three-row window, plus one row memory access per row.
// After reset, busy stays high while the grid is cleared row by row.
// Results are shown for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// Toroidal life grid
// Holds a wrapped grid of one-bit cells in a row memory and advances it by
// the B3/S23 rule, one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module life_cellular_automaton_grid #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  lcag_pkg::in_t in_data,
  output logic          busy,
  output logic          out_valid,
  output lcag_pkg::out_t out_data
);

  import lcag_pkg::*;

  localparam int CW = $clog2(GRID_WIDTH);
  localparam int AW = $clog2(GRID_HEIGHT);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CELL  = 4'd2;
  localparam logic [3:0] S_LD0   = 4'd3;
  localparam logic [3:0] S_LD1   = 4'd4;
  localparam logic [3:0] S_LD2   = 4'd5;
  localparam logic [3:0] S_LD3   = 4'd6;
  localparam logic [3:0] S_CALC  = 4'd7;
  localparam logic [3:0] S_WROW  = 4'd8;
  localparam logic [3:0] S_FETCH = 4'd9;

  logic [3:0]            state_r, state_nxt;
  logic [AW-1:0]         row_cnt_r, row_cnt_nxt;
  logic [CW-1:0]         col_cnt_r, col_cnt_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [CW-1:0]         cidx_r, cidx_nxt;
  logic                  cin_r, cin_nxt;
  logic [GRID_WIDTH-1:0] prev_r, prev_nxt;
  logic [GRID_WIDTH-1:0] cur_r, cur_nxt;
  logic [GRID_WIDTH-1:0] nxt_row_r, nxt_row_nxt;
  logic [GRID_WIDTH-1:0] row0_r, row0_nxt;
  logic [GRID_WIDTH-1:0] res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [GRID_WIDTH-1:0] wr_data;
  logic [AW-1:0]         rd_addr;
  logic [GRID_WIDTH-1:0] rd_data;

  logic [3:0]            nb_cnt;
  logic                  new_cell;
  logic                  in_range;
  logic [AW:0]           ahead_row;

  lcag_ram #(
    .WIDTH(GRID_WIDTH),
    .DEPTH(GRID_HEIGHT)
  ) u_grid (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Bit 0 of each window row is the current column; bit 1 and the top bit are its neighbors.
  always_comb begin
    nb_cnt = 4'(prev_r[GRID_WIDTH-1]) + 4'(prev_r[0]) + 4'(prev_r[1])
           + 4'(cur_r[GRID_WIDTH-1]) + 4'(cur_r[1])
           + 4'(nxt_row_r[GRID_WIDTH-1]) + 4'(nxt_row_r[0]) + 4'(nxt_row_r[1]);
    if (cur_r[0]) begin
      new_cell = (nb_cnt == SURVIVE_MIN) || (nb_cnt == BIRTH_COUNT);
    end else begin
      new_cell = (nb_cnt == BIRTH_COUNT);
    end
  end

  always_comb begin
    in_range  = ({3'b000, in_data.col} < 9'(GRID_WIDTH)) &&
                ({3'b000, in_data.row} < 9'(GRID_HEIGHT));
    ahead_row = {1'b0, row_cnt_r} + (AW+1)'(2);
  end

  always_comb begin
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    col_cnt_nxt   = col_cnt_r;
    op_nxt        = op_r;
    cidx_nxt      = cidx_r;
    cin_nxt       = cin_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    nxt_row_nxt   = nxt_row_r;
    row0_nxt      = row0_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = row_cnt_r;
    wr_data       = res_r;
    rd_addr       = row_cnt_r;

    unique case (state_r)
      S_CLEAR: begin
        wr_en       = 1'b1;
        wr_data     = '0;
        row_cnt_nxt = row_cnt_r + AW'(1);
        if (row_cnt_r == AW'(GRID_HEIGHT - 1)) begin
          row_cnt_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt      = in_data.opcode;
          cidx_nxt    = CW'(in_data.col);
          cin_nxt     = in_data.cell_in;
          row_cnt_nxt = AW'(in_data.row);
          unique case (in_data.opcode) inside
            OP_WRITE, OP_READ: begin
              if (in_range) begin
                rd_addr   = AW'(in_data.row);
                state_nxt = S_CELL;
              end else begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{cell_out: 1'b0, done_opcode: in_data.opcode};
              end
            end
            OP_ADV: begin
              state_nxt = S_LD0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{cell_out: 1'b0, done_opcode: in_data.opcode};
            end
          endcase
        end
      end
      S_CELL: begin
        wr_data        = rd_data;
        wr_data[cidx_r] = cin_r;
        wr_en          = (op_r == OP_WRITE);
        out_valid_nxt  = 1'b1;
        out_data_nxt   = '{cell_out: (op_r == OP_READ) ? rd_data[cidx_r] : 1'b0,
                           done_opcode: op_r};
        state_nxt      = S_IDLE;
      end
      S_LD0: begin
        rd_addr   = AW'(GRID_HEIGHT - 1);
        state_nxt = S_LD1;
      end
      S_LD1: begin
        prev_nxt  = rd_data;
        rd_addr   = '0;
        state_nxt = S_LD2;
      end
      S_LD2: begin
        cur_nxt   = rd_data;
        row0_nxt  = rd_data;
        rd_addr   = AW'(1);
        state_nxt = S_LD3;
      end
      S_LD3: begin
        nxt_row_nxt = rd_data;
        row_cnt_nxt = '0;
        col_cnt_nxt = '0;
        state_nxt   = S_CALC;
      end
      S_CALC: begin
        prev_nxt    = {prev_r[0], prev_r[GRID_WIDTH-1:1]};
        cur_nxt     = {cur_r[0], cur_r[GRID_WIDTH-1:1]};
        nxt_row_nxt = {nxt_row_r[0], nxt_row_r[GRID_WIDTH-1:1]};
        res_nxt     = {new_cell, res_r[GRID_WIDTH-1:1]};
        col_cnt_nxt = col_cnt_r + CW'(1);
        if (col_cnt_r == CW'(GRID_WIDTH - 1)) begin
          state_nxt = S_WROW;
        end
      end
      S_WROW: begin
        wr_en    = 1'b1;
        prev_nxt = cur_r;
        cur_nxt  = nxt_row_r;
        if (row_cnt_r == AW'(GRID_HEIGHT - 1)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{cell_out: 1'b0, done_opcode: OP_ADV};
          state_nxt     = S_IDLE;
        end else if (ahead_row < (AW+1)'(GRID_HEIGHT)) begin
          rd_addr   = ahead_row[AW-1:0];
          state_nxt = S_FETCH;
        end else begin
          nxt_row_nxt = row0_r;
          row_cnt_nxt = row_cnt_r + AW'(1);
          col_cnt_nxt = '0;
          state_nxt   = S_CALC;
        end
      end
      S_FETCH: begin
        nxt_row_nxt = rd_data;
        row_cnt_nxt = row_cnt_r + AW'(1);
        col_cnt_nxt = '0;
        state_nxt   = S_CALC;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    cidx_r     <= cidx_nxt;
    cin_r      <= cin_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    nxt_row_r  <= nxt_row_nxt;
    row0_r     <= row0_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/core/lcag_checker.sv
// ----------------------------------------------------------------------------
// Life grid checker
// Port-level checks on the life grid's transactions over time.
// ----------------------------------------------------------------------------
`default_nettype none

module lcag_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           start,
  input wire lcag_pkg::in_t  in_data,
  input wire logic           busy,
  input wire logic           out_valid,
  input wire lcag_pkg::out_t out_data
);

  import lcag_pkg::*;

  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> busy)
    else $error("grid not busy while clearing after reset");

  a_adv_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.opcode == OP_ADV)) |=> busy)
    else $error("advance transaction did not make the grid busy");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_cell_out_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.done_opcode != OP_READ)) |-> !out_data.cell_out)
    else $error("cell_out set on a transaction that is not a read");

  a_adv_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.done_opcode == OP_ADV)) |-> $past(busy))
    else $error("advance result without a preceding busy period");

endmodule

bind life_cellular_automaton_grid lcag_checker u_lcag_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .in_data  (in_data),
  .busy     (busy),
  .out_valid(out_valid),
  .out_data (out_data)
);

`default_nettype wire
